FILE: hw/rtl/point_in_polygon_crossing_assert.svh
// Assertion macros for the point-in-polygon crossing block
`ifndef POINT_IN_POLYGON_CROSSING_ASSERT_SVH
`define POINT_IN_POLYGON_CROSSING_ASSERT_SVH
`define PIP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/pip_pkg.sv
// Shared constants and types for the point-in-polygon crossing block
package pip_pkg;
  localparam int unsigned MAX_EDGES_DEF = 64;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned DIV_W = 64;
  localparam int unsigned CFG_IDX_W = 32;
  localparam logic signed [COORD_W-1:0] MINUS_ONE_Q16 = -32'sd65536;
  localparam logic signed [COORD_W:0] ONE_Q16 = 33'sd65536;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X = 32'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y = 32'd1;

  typedef struct packed {
    logic store;
    logic clear;
    logic load_edge;
    logic start_div;
    logic judge;
  } pip_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_last;
  } pip_sts_t;
endpackage

FILE: hw/rtl/pip_if.sv
// Valid/ready channel interface
interface pip_if #(parameter int unsigned W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/pip_datapath.sv
// Edge store, min-x tracking, crossing divider and counter
module pip_datapath #(
  parameter int unsigned MAX_EDGES = pip_pkg::MAX_EDGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  pip_pkg::pip_cmd_t cmd,
  output pip_pkg::pip_sts_t sts,
  input  logic [127:0] in_edge,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_y,
  output logic [pip_pkg::CNT_W-1:0] cnt_out,
  output logic dropped_out
);
  import pip_pkg::*;
  localparam int unsigned IDX_W = $clog2(MAX_EDGES + 1);
  localparam int unsigned A_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  logic [127:0] mem [MAX_EDGES];
  logic [127:0] rd_r;
  logic [IDX_W-1:0] count_r, scan_r;
  logic signed [31:0] least_r;
  logic drop_r;
  logic [CNT_W-1:0] hits_r;
  logic signed [32:0] x1_r, hi_r, lo_r;
  logic neg_r, valid_r;
  logic [DIV_W-1:0] num_r, quo_r;
  logic [DIV_W:0] rem_r;
  logic [32:0] den_r;
  logic [6:0] step_r;
  logic busy_r;

  logic signed [31:0] ex1, ey1, ex2, ey2, nl;
  logic signed [32:0] dy, dx, qd, st;
  logic [32:0] ady, adx, aqd;
  logic [DIV_W:0] trial;
  logic signed [34:0] cx;

  always_comb begin
    {ex1, ey1, ex2, ey2} = rd_r;
    dy = 33'(ey2) - 33'(ey1);
    dx = 33'(ex2) - 33'(ex1);
    qd = 33'(query_y) - 33'(ey1);
    ady = dy[32] ? 33'(-dy) : dy;
    adx = dx[32] ? 33'(-dx) : dx;
    aqd = qd[32] ? 33'(-qd) : qd;
    nl = least_r;
    if ($signed(in_edge[127:96]) < nl) nl = in_edge[127:96];
    if ($signed(in_edge[63:32]) < nl) nl = in_edge[63:32];
    st = 33'(least_r) - ONE_Q16;
    trial = {rem_r[DIV_W-1:0], num_r[DIV_W-1]} - {32'd0, den_r};
    cx = neg_r ? 35'(x1_r) - $signed({1'b0, quo_r[33:0]})
               : 35'(x1_r) + $signed({1'b0, quo_r[33:0]});
  end

  always_ff @(posedge clk) begin
    if (cmd.store && count_r < IDX_W'(MAX_EDGES)) mem[count_r[A_W-1:0]] <= in_edge;
    rd_r <= mem[scan_r[A_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; least_r <= MINUS_ONE_Q16; drop_r <= 1'b0;
      scan_r <= '0; hits_r <= '0; busy_r <= 1'b0;
    end else begin
      if (cmd.store) begin
        if (count_r < IDX_W'(MAX_EDGES)) begin
          count_r <= count_r + 1'b1; least_r <= nl;
        end else drop_r <= 1'b1;
      end
      if (cmd.load_edge) begin
        lo_r <= (st < 33'(query_x)) ? st : 33'(query_x);
        hi_r <= (st < 33'(query_x)) ? 33'(query_x) : st;
        x1_r <= 33'(ex1); neg_r <= (ex2 < ex1);
        valid_r <= (ey1 != ey2) && !((query_y < ey1) && (query_y < ey2))
                   && !((query_y > ey1) && (query_y > ey2));
        num_r <= DIV_W'(aqd[31:0]) * DIV_W'(adx[31:0]) + (aqd[32] ? DIV_W'(adx) << 32 : '0)
                 + (adx[32] ? DIV_W'(aqd[31:0]) << 32 : '0);
        den_r <= (ady == '0) ? 33'd1 : ady;
      end
      if (cmd.start_div) begin
        busy_r <= 1'b1; step_r <= '0; rem_r <= '0; quo_r <= '0;
      end else if (busy_r) begin
        if (!trial[DIV_W]) rem_r <= trial; else rem_r <= {rem_r[DIV_W-1:0], num_r[DIV_W-1]};
        quo_r <= {quo_r[DIV_W-2:0], !trial[DIV_W]};
        num_r <= num_r << 1;
        step_r <= step_r + 1'b1;
        if (step_r == 7'(DIV_W - 1)) busy_r <= 1'b0;
      end
      if (cmd.judge) begin
        if (valid_r && quo_r[DIV_W-1:34] == '0 && cx >= 35'(lo_r) && cx <= 35'(hi_r))
          hits_r <= hits_r + 1'b1;
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.clear) begin
        count_r <= '0; least_r <= MINUS_ONE_Q16; drop_r <= 1'b0;
        scan_r <= '0; hits_r <= '0;
      end
    end
  end

  assign sts.div_done = busy_r && step_r == 7'(DIV_W - 1);
  assign sts.scan_last = (scan_r >= count_r);
  assign cnt_out = hits_r;
  assign dropped_out = drop_r;
endmodule

FILE: hw/rtl/pip_ctrl.sv
// Controller for edge intake, scan and result handoff
module pip_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic in_last,
  input  logic out_ready,
  output logic in_ready,
  output logic out_valid,
  output logic load_res,
  output pip_pkg::pip_cmd_t cmd,
  input  pip_pkg::pip_sts_t sts
);
  import pip_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_RD, S_LOAD, S_DIV, S_JUDGE, S_OUT} state_t;
  state_t state_r;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0;
    end else begin
      if (load_res) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_fire && in_last) state_r <= S_RD;
        S_RD: state_r <= sts.scan_last ? S_OUT : S_LOAD;
        S_LOAD: state_r <= S_DIV;
        S_DIV: if (sts.div_done) state_r <= S_JUDGE;
        S_JUDGE: state_r <= S_RD;
        S_OUT: if (load_res) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.store = in_fire;
    cmd.load_edge = (state_r == S_LOAD);
    cmd.start_div = (state_r == S_LOAD);
    cmd.judge = (state_r == S_JUDGE);
    load_res = (state_r == S_OUT) && (!out_valid_r || out_ready);
    cmd.clear = load_res;
  end
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
endmodule

FILE: hw/rtl/point_in_polygon_crossing.sv
// Top level of the even-odd point-in-polygon crossing block
// Usage:
//   in_*  : one polygon edge per transfer (x1,y1,x2,y2 Q16.16, last_edge).
//   cfg_* : writes query_x (index 0) or query_y (index 1) while idle.
//   out_* : one result per polygon (inside_res, crossings, overflowed).
// Edges that are not last are simply stored. The last edge starts a scan
// over the stored edges: each is read, loaded, divided by the 64-step shift
// subtract divider that computes the crossing x, and judged. No input is
// taken during the scan. The result sits in an output register; a stalled
// receiver holds it, and the next polygon's edges are accepted meanwhile,
// its own result waiting until the register is free. Edges beyond MAX_EDGES
// are dropped and flagged. Reset clears the edge count, least x (-1.0), drop
// flag and queries.
module point_in_polygon_crossing #(
  parameter int unsigned MAX_EDGES = pip_pkg::MAX_EDGES_DEF
) (
  input logic clk,
  input logic rst_n,
  pip_if.sink in_ch,
  pip_if.source out_ch,
  pip_if.sink cfg_ch
);
  import pip_pkg::*;
  pip_cmd_t cmd;
  pip_sts_t sts;
  logic in_fire, load_res;
  logic signed [31:0] qx_r, qy_r;
  logic [CNT_W-1:0] cnt;
  logic drop;
  logic [8:0] res_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0; qy_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data[63:32])
        CFG_QUERY_X: qx_r <= cfg_ch.data[31:0];
        CFG_QUERY_Y: qy_r <= cfg_ch.data[31:0];
        default: ;
      endcase
    end
  end

  assign in_fire = in_ch.valid && in_ch.ready;

  pip_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_last(in_ch.data[0]), .out_ready(out_ch.ready),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .load_res, .cmd, .sts
  );

  pip_datapath #(.MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_edge(in_ch.data[128:1]),
    .query_x(qx_r), .query_y(qy_r), .cnt_out(cnt), .dropped_out(drop)
  );

  always_ff @(posedge clk) if (load_res) res_r <= {cnt[0], cnt, drop};
  assign out_ch.data = res_r;
endmodule

FILE: hw/rtl/pip_checker.sv
// Port-level checker bound to the top level
`include "point_in_polygon_crossing_assert.svh"
module pip_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [8:0] out_data
);
  `PIP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `PIP_ASSERT_IMPL(a_parity, clk, rst_n, out_valid, out_data[8] == out_data[1])
  `PIP_ASSERT_IMPL(a_ready_after_out_set, clk, rst_n, $rose(out_valid), in_ready)
endmodule

bind point_in_polygon_crossing pip_checker u_chk (
  .clk, .rst_n, .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
